// ===== hw/rtl/ptuw_pkg.sv =====
package ptuw_pkg;

	// Walk sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LOOKUP,
		S_EVAL,
		S_FINISH
	} state_t;

	// Result status codes
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_INVALID       = 3'd1;
	localparam logic [2:0] ST_RANGE         = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_SUPPORTED = 3'd4;

	// Walk levels, also the cleared level codes
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;
	localparam logic [1:0] CLR_NONE = 2'd0;

	// Table entry layout
	localparam int ENTRY_PRESENT_BIT = 0;
	localparam int ENTRY_LARGE_BIT   = 7;
	localparam int ENTRIES_PER_TABLE = 512;

	// Mode codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_UNMAP = 1'b1;

endpackage

// ===== hw/rtl/page_table_unmap_walker_unit.sv =====
// Page-table unmap walker.
// Input channel (in_valid / in_stall) carries one beat per item: mode 0 stores
// word_data at byte address word_address into the internal table memory,
// mode 1 walks the four-level table from root_address for virtual_address and
// clears the entry that maps it (large entries only when allow_large is set).
// Output channel (out_valid / out_stall) returns exactly one beat per item:
// status, cleared_level and invalidate. invalidate is set when an entry was
// cleared and root_address equals the active_root register (cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, and the
// block does not enforce this). Timing: the walker holds one item at a time.
// A write, or an unmap with a misaligned virtual address, is decided in the
// decode state; each table read passes a lookup state (table address check and
// registered memory read) and an evaluate state, and an unmap stops in the
// lookup state at a table past the end of memory. The next beat is accepted in
// the cycle after the result is loaded into the output register.
// The result sits in an output register; while out_stall holds it, the
// walker may finish the next item and then waits with it until the register
// frees. Reset clears the sequencer, the output valid and active_root; the
// table memory holds nothing defined until written.
module page_table_unmap_walker_unit #(
	parameter int TABLE_WORDS = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [51:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] word_address,
	input  logic [63:0] word_data,
	input  logic [51:0] root_address,
	input  logic [47:0] virtual_address,
	input  logic        allow_large,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [1:0]  cleared_level,
	output logic        invalidate
);

	import ptuw_pkg::*;

	localparam int AW         = $clog2(TABLE_WORDS);
	localparam int NUM_TABLES = TABLE_WORDS / ENTRIES_PER_TABLE;

	state_t state_q, state_d;

	logic [51:0]   active_root_q;
	logic          mode_q;
	logic [15:0]   waddr_q;
	logic [63:0]   wdata_q;
	logic [51:0]   root_q;
	logic [47:0]   va_q;
	logic          allow_q;
	logic [39:0]   page_q;
	logic [1:0]    lvl_q;
	logic [AW-1:0] slot_q;

	logic [2:0] res_status_q;
	logic [1:0] res_level_q;
	logic       res_inv_q;
	logic       out_valid_q;
	logic [2:0] out_status_q;
	logic [1:0] out_level_q;
	logic       out_inv_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	logic       in_take;
	logic       out_free;
	logic       res_load;
	logic [2:0] res_status_d;
	logic [1:0] res_level_d;
	logic       res_inv_d;

	// Write item checks
	logic [12:0] wr_word;
	logic        wr_misaligned;
	logic        wr_in_range;

	// Walk checks
	logic          va_misaligned;
	logic          table_fits;
	logic [8:0]    level_index;
	logic [AW-1:0] slot_addr;
	logic          entry_present;
	logic          entry_terminal;
	logic          entry_refused;

	ptuw_ram #(
		.WIDTH(64),
		.DEPTH(TABLE_WORDS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign wr_word       = waddr_q[15:3];
	assign wr_misaligned = |waddr_q[2:0];
	assign wr_in_range   = 32'(wr_word) < TABLE_WORDS;
	assign va_misaligned = |va_q[11:0];
	assign table_fits    = page_q < 40'(NUM_TABLES);
	assign slot_addr     = {page_q[AW-10:0], level_index};

	// Pick the table index for the current level
	always_comb begin
		unique case (lvl_q)
			LVL_PML4: level_index = va_q[47:39];
			LVL_PDPT: level_index = va_q[38:30];
			LVL_PD:   level_index = va_q[29:21];
			LVL_PT:   level_index = va_q[20:12];
			default:  level_index = va_q[20:12];
		endcase
	end

	assign entry_present  = ram_rdata[ENTRY_PRESENT_BIT];
	assign entry_terminal = (lvl_q == LVL_PT) ||
		(((lvl_q == LVL_PDPT) || (lvl_q == LVL_PD)) && ram_rdata[ENTRY_LARGE_BIT]);
	assign entry_refused  = (lvl_q != LVL_PT) && !allow_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (mode_q == MODE_UNMAP && !va_misaligned) begin
					state_d = S_LOOKUP;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_LOOKUP: begin
				state_d = table_fits ? S_EVAL : S_FINISH;
			end
			S_EVAL: begin
				if (!entry_present || entry_terminal) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_LOOKUP;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls and result decisions
	always_comb begin
		in_stall     = 1'b1;
		ram_we       = 1'b0;
		ram_waddr    = slot_q;
		ram_wdata    = '0;
		ram_raddr    = slot_addr;
		res_load     = 1'b0;
		res_status_d = ST_OK;
		res_level_d  = CLR_NONE;
		res_inv_d    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_DECODE: begin
				if (mode_q == MODE_WRITE) begin
					res_load = 1'b1;
					if (wr_misaligned) begin
						res_status_d = ST_INVALID;
					end else if (!wr_in_range) begin
						res_status_d = ST_RANGE;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = AW'(wr_word);
						ram_wdata = wdata_q;
					end
				end else if (va_misaligned) begin
					res_load     = 1'b1;
					res_status_d = ST_INVALID;
				end
			end
			S_LOOKUP: begin
				if (!table_fits) begin
					res_load     = 1'b1;
					res_status_d = ST_RANGE;
				end
			end
			S_EVAL: begin
				if (!entry_present) begin
					res_load     = 1'b1;
					res_status_d = ST_NOT_FOUND;
				end else if (entry_terminal) begin
					res_load = 1'b1;
					if (entry_refused) begin
						res_status_d = ST_NOT_SUPPORTED;
					end else begin
						ram_we      = 1'b1;
						res_level_d = lvl_q;
						res_inv_d   = (root_q == active_root_q);
					end
				end
			end
			S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			active_root_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				active_root_q <= cfg_wr_data;
			end
			// Drop the beat once taken, load a finished result when free
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, walk and result registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q  <= mode;
			waddr_q <= word_address;
			wdata_q <= word_data;
			root_q  <= root_address;
			va_q    <= virtual_address;
			allow_q <= allow_large;
		end
		// Start the walk at the root table
		if (state_q == S_DECODE) begin
			page_q <= root_q[51:12];
			lvl_q  <= LVL_PML4;
		end
		if (state_q == S_LOOKUP) begin
			slot_q <= slot_addr;
		end
		// Advance to the next-level table
		if (state_q == S_EVAL && entry_present && !entry_terminal) begin
			page_q <= ram_rdata[51:12];
			lvl_q  <= lvl_q + 2'd1;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_level_q  <= res_level_d;
			res_inv_q    <= res_inv_d;
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_level_q  <= res_level_q;
			out_inv_q    <= res_inv_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign cleared_level = out_level_q;
	assign invalidate    = out_inv_q;

endmodule

// ===== hw/rtl/ptuw_ram.sv =====
module ptuw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
